[rtl/core/bpm_pkg.sv]
// bpm_pkg: shared types, constants and lookup functions of the battery power monitor
// used by bpm_alu, bpm_regs, bpm_ctrl and battery_power_monitor; no dependencies
package bpm_pkg;

    localparam int MV_W     = 13;
    localparam int ADC_W    = 12;
    localparam int FRAC_W   = 8;
    localparam int FV_W     = MV_W + FRAC_W;
    localparam int W_W      = 9;
    localparam int PCT_W    = 7;
    localparam int PWR_W    = 3;
    localparam int LOW_W    = 4;
    localparam int DEB_W    = 2;
    localparam int ALU_W    = 24;
    localparam int PROD_W   = 2 * ALU_W;
    localparam int MAGIC_W  = 14;
    localparam int X_W      = 10;
    localparam int Q_W      = 6;
    localparam int RECIP_SH = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int IDX_W    = 3;

    localparam int LOW_LIMIT_DEF      = 10;
    localparam int DEBOUNCE_LIMIT_DEF = 3;

    localparam logic [MV_W-1:0]    MV_MAX      = 13'd8191;
    localparam logic [MV_W:0]      RAW_OFS     = 14'd65;
    localparam logic [W_W-1:0]     W_FULL      = 9'd256;
    localparam logic [PCT_W-1:0]   PCT_CHRG    = 7'd101;
    localparam logic [PCT_W-1:0]   PCT_USB     = 7'd102;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY   = 7'd0;

    localparam logic [MV_W-1:0] RST_STEP_THR = 13'd100;
    localparam logic [W_W-1:0]  RST_SMOOTH   = 9'd26;
    localparam logic [MV_W-1:0] RST_USB_MV   = 13'd4180;
    localparam logic [MV_W-1:0] RST_MIN_MV   = 13'd3300;
    localparam logic [MV_W-1:0] RST_CHG_THR  = 13'd20;

    typedef enum logic [IDX_W-1:0] {
        REG_STEP_THR = 3'd0,
        REG_SMOOTH   = 3'd1,
        REG_USB_MV   = 3'd2,
        REG_MIN_MV   = 3'd3,
        REG_CHG_THR  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [MV_W-1:0] step_thr;
        logic [W_W-1:0]  smooth;
        logic [MV_W-1:0] usb_mv;
        logic [MV_W-1:0] min_mv;
        logic [MV_W-1:0] chg_thr;
    } cfg_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef enum logic [PWR_W-1:0] {
        PWR_INIT = 3'd0,
        PWR_USB  = 3'd1,
        PWR_CHRG = 3'd2,
        PWR_FULL = 3'd3,
        PWR_RUN  = 3'd4,
        PWR_LOW  = 3'd5
    } pwr_t;

    typedef enum logic [2:0] {
        SEG_NONE = 3'd0,
        SEG_3300 = 3'd1,
        SEG_3500 = 3'd2,
        SEG_3650 = 3'd3,
        SEG_3800 = 3'd4,
        SEG_TOP  = 3'd5
    } seg_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_DIFF   = 4'd1,
        ST_STEP   = 4'd2,
        ST_MUL    = 4'd3,
        ST_FADD   = 4'd4,
        ST_FWR    = 4'd5,
        ST_USBCMP = 4'd6,
        ST_MINCMP = 4'd7,
        ST_PSTATE = 4'd8,
        ST_CHG1   = 4'd9,
        ST_CHG2   = 4'd10,
        ST_PMUL   = 4'd11,
        ST_PFIN   = 4'd12,
        ST_REPORT = 4'd13,
        ST_DONE   = 4'd14
    } ctl_state_t;

    // millivolts to Q13.8 on the alu operand width
    function automatic logic [ALU_W-1:0] to_q8(input logic [MV_W-1:0] mv);
        return {{(ALU_W-FV_W){1'b0}}, mv, {FRAC_W{1'b0}}};
    endfunction

    function automatic seg_t seg_of(input logic [MV_W-1:0] mv);
        seg_t s;
        if (mv >= 13'd4000)      s = SEG_TOP;
        else if (mv >= 13'd3800) s = SEG_3800;
        else if (mv >= 13'd3650) s = SEG_3650;
        else if (mv >= 13'd3500) s = SEG_3500;
        else if (mv >= 13'd3300) s = SEG_3300;
        else                     s = SEG_NONE;
        return s;
    endfunction

    function automatic logic [MV_W-1:0] seg_base(input seg_t s);
        logic [MV_W-1:0] b;
        unique case (s)
            SEG_3300: b = 13'd3300;
            SEG_3500: b = 13'd3500;
            SEG_3650: b = 13'd3650;
            SEG_3800: b = 13'd3800;
            default:  b = 13'd0;
        endcase
        return b;
    endfunction

    // ceil(2^16 / d), exact for the slope divisors 20, 5, 15 and 10 below 1024
    function automatic logic [MAGIC_W-1:0] seg_magic(input seg_t s);
        logic [MAGIC_W-1:0] m;
        unique case (s)
            SEG_3300: m = 14'd3277;
            SEG_3500: m = 14'd13108;
            SEG_3650: m = 14'd4370;
            SEG_3800: m = 14'd6554;
            default:  m = 14'd0;
        endcase
        return m;
    endfunction

    function automatic logic [PCT_W-1:0] seg_offset(input seg_t s);
        logic [PCT_W-1:0] o;
        unique case (s)
            SEG_3500: o = 7'd10;
            SEG_3650: o = 7'd40;
            SEG_3800: o = 7'd80;
            default:  o = 7'd0;
        endcase
        return o;
    endfunction

endpackage

[rtl/core/bpm_alu.sv]
// bpm_alu: shared add, subtract and multiply unit with a registered result
// depends on bpm_pkg
module bpm_alu (
    input  logic                                aclk,
    input  bpm_pkg::alu_req_t                   req,
    output logic signed [bpm_pkg::PROD_W-1:0]   y
);

    logic signed [bpm_pkg::ALU_W-1:0]  a_s;
    logic signed [bpm_pkg::ALU_W-1:0]  b_s;
    logic signed [bpm_pkg::PROD_W-1:0] y_next;
    logic signed [bpm_pkg::PROD_W-1:0] y_reg;

    assign a_s = req.a;
    assign b_s = req.b;

    always_comb begin
        unique case (req.op)
            bpm_pkg::ALU_ADD: y_next = bpm_pkg::PROD_W'(a_s) + bpm_pkg::PROD_W'(b_s);
            bpm_pkg::ALU_SUB: y_next = bpm_pkg::PROD_W'(a_s) - bpm_pkg::PROD_W'(b_s);
            bpm_pkg::ALU_MUL: y_next = a_s * b_s;
            default:          y_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

[rtl/core/bpm_regs.sv]
// bpm_regs: apb configuration registers of the battery power monitor
// depends on bpm_pkg
module bpm_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpm_pkg::APB_AW-1:0]    paddr,
    input  logic [bpm_pkg::APB_DW-1:0]    pwdata,
    output logic [bpm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output bpm_pkg::cfg_t                 cfg
);

    bpm_pkg::cfg_t     cfg_reg;
    bpm_pkg::cfg_t     cfg_next;
    bpm_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = bpm_pkg::reg_idx_t'(paddr[bpm_pkg::APB_AW-1:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                bpm_pkg::REG_STEP_THR: cfg_next.step_thr = pwdata[bpm_pkg::MV_W-1:0];
                bpm_pkg::REG_SMOOTH:   cfg_next.smooth   = pwdata[bpm_pkg::W_W-1:0];
                bpm_pkg::REG_USB_MV:   cfg_next.usb_mv   = pwdata[bpm_pkg::MV_W-1:0];
                bpm_pkg::REG_MIN_MV:   cfg_next.min_mv   = pwdata[bpm_pkg::MV_W-1:0];
                bpm_pkg::REG_CHG_THR:  cfg_next.chg_thr  = pwdata[bpm_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bpm_pkg::REG_STEP_THR: prdata = bpm_pkg::APB_DW'(cfg_reg.step_thr);
            bpm_pkg::REG_SMOOTH:   prdata = bpm_pkg::APB_DW'(cfg_reg.smooth);
            bpm_pkg::REG_USB_MV:   prdata = bpm_pkg::APB_DW'(cfg_reg.usb_mv);
            bpm_pkg::REG_MIN_MV:   prdata = bpm_pkg::APB_DW'(cfg_reg.min_mv);
            bpm_pkg::REG_CHG_THR:  prdata = bpm_pkg::APB_DW'(cfg_reg.chg_thr);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_thr <= bpm_pkg::RST_STEP_THR;
            cfg_reg.smooth   <= bpm_pkg::RST_SMOOTH;
            cfg_reg.usb_mv   <= bpm_pkg::RST_USB_MV;
            cfg_reg.min_mv   <= bpm_pkg::RST_MIN_MV;
            cfg_reg.chg_thr  <= bpm_pkg::RST_CHG_THR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/bpm_ctrl.sv]
// bpm_ctrl: sequencer, filter and power state, percent lookup and result buffer
// depends on bpm_pkg; drives the shared bpm_alu through an alu_req_t
module bpm_ctrl #(
    parameter int LOW_LIMIT      = bpm_pkg::LOW_LIMIT_DEF,
    parameter int DEBOUNCE_LIMIT = bpm_pkg::DEBOUNCE_LIMIT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bpm_pkg::cfg_t                       cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bpm_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bpm_pkg::M_DATA_W-1:0]        m_tdata,
    output bpm_pkg::alu_req_t                   alu_req,
    input  logic signed [bpm_pkg::PROD_W-1:0]   alu_y
);

    localparam int FV_W  = bpm_pkg::FV_W;
    localparam int MV_W  = bpm_pkg::MV_W;
    localparam int ALU_W = bpm_pkg::ALU_W;

    bpm_pkg::ctl_state_t state_reg, state_next;
    bpm_pkg::pwr_t       pwr_reg, pwr_next, prev_reg, prev_next, pwr_new;
    bpm_pkg::seg_t       seg_reg, seg_next;

    logic [FV_W-1:0]              fv_reg, fv_next, rq_reg, rq_next;
    logic signed [FV_W:0]         d_reg, d_next;
    logic                         primed_reg, primed_next;
    logic                         pin_reg, pin_next;
    logic [bpm_pkg::LOW_W-1:0]    low_reg, low_next;
    logic [bpm_pkg::DEB_W-1:0]    deb_reg, deb_next;
    logic                         sflag_reg, sflag_next, vflag_reg, vflag_next;
    logic [MV_W-1:0]              last_reg, last_next;
    logic                         usb_gt_reg, usb_gt_next;
    logic [bpm_pkg::PCT_W-1:0]    pct_reg, pct_next;
    logic                         usb_out_reg, usb_out_next;
    logic                         sleep_out_reg, sleep_out_next;
    logic                         chg_out_reg, chg_out_next;
    logic                         m_valid_reg, m_valid_next;
    logic [bpm_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                         y_neg;
    logic signed [ALU_W-1:0]      y_lo;
    logic [ALU_W-1:0]             y_abs;
    logic [MV_W-1:0]              mag;
    logic [bpm_pkg::W_W-1:0]      weight;
    logic [MV_W:0]                raw_sum;
    logic [MV_W-1:0]              raw_mv;
    logic [bpm_pkg::X_W-1:0]      pct_x;
    logic [bpm_pkg::Q_W-1:0]      pct_q;
    logic                         usb_now;
    logic                         ch;

    assign y_neg   = alu_y[bpm_pkg::PROD_W-1];
    assign y_lo    = alu_y[ALU_W-1:0];
    assign y_abs   = y_neg ? ALU_W'(-y_lo) : ALU_W'(y_lo);
    assign mag     = fv_reg[FV_W-1:bpm_pkg::FRAC_W];
    assign weight  = (cfg.smooth > bpm_pkg::W_FULL) ? bpm_pkg::W_FULL : cfg.smooth;
    assign raw_sum = {1'b0, s_tdata[bpm_pkg::ADC_W-1:0], 1'b0} + bpm_pkg::RAW_OFS;
    assign raw_mv  = (raw_sum > {1'b0, bpm_pkg::MV_MAX}) ? bpm_pkg::MV_MAX
                                                         : raw_sum[MV_W-1:0];
    assign pct_x   = (seg_reg == bpm_pkg::SEG_3650) ? alu_y[15:6] : alu_y[17:8];
    assign pct_q   = alu_y[bpm_pkg::RECIP_SH +: bpm_pkg::Q_W];
    assign usb_now = usb_gt_reg | pin_reg;
    assign ch      = sflag_reg | vflag_reg;

    always_comb begin
        state_next     = state_reg;
        pwr_next       = pwr_reg;
        prev_next      = prev_reg;
        pwr_new        = pwr_reg;
        seg_next       = seg_reg;
        fv_next        = fv_reg;
        rq_next        = rq_reg;
        d_next         = d_reg;
        primed_next    = primed_reg;
        pin_next       = pin_reg;
        low_next       = low_reg;
        deb_next       = deb_reg;
        sflag_next     = sflag_reg;
        vflag_next     = vflag_reg;
        last_next      = last_reg;
        usb_gt_next    = usb_gt_reg;
        pct_next       = pct_reg;
        usb_out_next   = usb_out_reg;
        sleep_out_next = sleep_out_reg;
        chg_out_next   = chg_out_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        alu_req.op     = bpm_pkg::ALU_SUB;
        alu_req.a      = '0;
        alu_req.b      = '0;

        unique case (state_reg)
            bpm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rq_next  = {raw_mv, {bpm_pkg::FRAC_W{1'b0}}};
                    pin_next = s_tdata[bpm_pkg::ADC_W];
                    state_next = s_tuser ? bpm_pkg::ST_REPORT : bpm_pkg::ST_DIFF;
                end
            end
            bpm_pkg::ST_DIFF: begin
                alu_req.a  = ALU_W'(rq_reg);
                alu_req.b  = ALU_W'(fv_reg);
                state_next = bpm_pkg::ST_STEP;
            end
            bpm_pkg::ST_STEP: begin
                d_next     = alu_y[FV_W:0];
                alu_req.a  = bpm_pkg::to_q8(cfg.step_thr);
                alu_req.b  = y_abs;
                state_next = bpm_pkg::ST_MUL;
            end
            bpm_pkg::ST_MUL: begin
                if (!primed_reg || y_neg) begin
                    fv_next     = rq_reg;
                    primed_next = 1'b1;
                    state_next  = bpm_pkg::ST_USBCMP;
                end else begin
                    alu_req.op = bpm_pkg::ALU_MUL;
                    alu_req.a  = ALU_W'(weight);
                    alu_req.b  = ALU_W'(d_reg);
                    state_next = bpm_pkg::ST_FADD;
                end
            end
            bpm_pkg::ST_FADD: begin
                // floor shift of the weighted step keeps the truncating average
                alu_req.op = bpm_pkg::ALU_ADD;
                alu_req.a  = ALU_W'(fv_reg);
                alu_req.b  = alu_y[bpm_pkg::FRAC_W +: ALU_W];
                state_next = bpm_pkg::ST_FWR;
            end
            bpm_pkg::ST_FWR: begin
                fv_next     = alu_y[FV_W-1:0];
                primed_next = 1'b1;
                state_next  = bpm_pkg::ST_USBCMP;
            end
            bpm_pkg::ST_USBCMP: begin
                alu_req.a  = bpm_pkg::to_q8(cfg.usb_mv);
                alu_req.b  = ALU_W'(fv_reg);
                state_next = bpm_pkg::ST_MINCMP;
            end
            bpm_pkg::ST_MINCMP: begin
                usb_gt_next = y_neg;
                alu_req.a   = ALU_W'(fv_reg);
                alu_req.b   = bpm_pkg::to_q8(cfg.min_mv);
                state_next  = bpm_pkg::ST_PSTATE;
            end
            bpm_pkg::ST_PSTATE: begin
                sleep_out_next = 1'b0;
                if (usb_now) begin
                    low_next = '0;
                    deb_next = '0;
                    if (pin_reg) begin
                        pwr_new = bpm_pkg::PWR_CHRG;
                    end else if (usb_gt_reg && (pwr_reg == bpm_pkg::PWR_CHRG ||
                                                pwr_reg == bpm_pkg::PWR_FULL)) begin
                        pwr_new = bpm_pkg::PWR_FULL;
                    end else if (pwr_reg == bpm_pkg::PWR_INIT) begin
                        pwr_new = bpm_pkg::PWR_USB;
                    end
                end else if (pwr_reg == bpm_pkg::PWR_FULL ||
                             pwr_reg == bpm_pkg::PWR_INIT) begin
                    pwr_new  = bpm_pkg::PWR_RUN;
                    low_next = '0;
                    deb_next = '0;
                end else if (y_neg) begin
                    pwr_new = bpm_pkg::PWR_LOW;
                    if (low_reg < bpm_pkg::LOW_W'(LOW_LIMIT)) begin
                        low_next = low_reg + 1'b1;
                    end else begin
                        deb_next       = '0;
                        sleep_out_next = 1'b1;
                    end
                end else begin
                    low_next = '0;
                    if (deb_reg < bpm_pkg::DEB_W'(DEBOUNCE_LIMIT)) begin
                        deb_next = deb_reg + 1'b1;
                    end else begin
                        pwr_new = bpm_pkg::PWR_RUN;
                    end
                end
                pwr_next = pwr_new;
                if (pwr_new != prev_reg) begin
                    sflag_next = 1'b1;
                    prev_next  = pwr_new;
                end
                usb_out_next = usb_now;
                chg_out_next = 1'b0;
                alu_req.a    = ALU_W'(mag);
                alu_req.b    = ALU_W'(last_reg);
                state_next   = bpm_pkg::ST_CHG1;
            end
            bpm_pkg::ST_CHG1: begin
                alu_req.a  = y_abs;
                alu_req.b  = ALU_W'(cfg.chg_thr);
                state_next = bpm_pkg::ST_CHG2;
            end
            bpm_pkg::ST_CHG2: begin
                if (!y_neg) begin
                    vflag_next = 1'b1;
                end
                seg_next   = bpm_pkg::seg_of(mag);
                alu_req.a  = ALU_W'(fv_reg);
                alu_req.b  = bpm_pkg::to_q8(bpm_pkg::seg_base(bpm_pkg::seg_of(mag)));
                state_next = bpm_pkg::ST_PMUL;
            end
            bpm_pkg::ST_PMUL: begin
                alu_req.op = bpm_pkg::ALU_MUL;
                alu_req.a  = ALU_W'(pct_x);
                alu_req.b  = ALU_W'(bpm_pkg::seg_magic(seg_reg));
                state_next = bpm_pkg::ST_PFIN;
            end
            bpm_pkg::ST_PFIN: begin
                if (pwr_reg == bpm_pkg::PWR_CHRG) begin
                    pct_next = bpm_pkg::PCT_CHRG;
                end else if (pwr_reg == bpm_pkg::PWR_USB) begin
                    pct_next = bpm_pkg::PCT_USB;
                end else if (pwr_reg == bpm_pkg::PWR_FULL || seg_reg == bpm_pkg::SEG_TOP) begin
                    pct_next = bpm_pkg::PCT_FULL;
                end else if (seg_reg == bpm_pkg::SEG_NONE) begin
                    pct_next = bpm_pkg::PCT_EMPTY;
                end else begin
                    pct_next = bpm_pkg::seg_offset(seg_reg) + bpm_pkg::PCT_W'(pct_q);
                end
                state_next = bpm_pkg::ST_DONE;
            end
            bpm_pkg::ST_REPORT: begin
                if (ch) begin
                    last_next = mag;
                end
                sflag_next     = 1'b0;
                vflag_next     = 1'b0;
                chg_out_next   = ch;
                usb_out_next   = 1'b0;
                sleep_out_next = 1'b0;
                state_next     = bpm_pkg::ST_DONE;
            end
            bpm_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {6'b0, chg_out_reg, sleep_out_reg, usb_out_reg,
                                    pct_reg, pwr_reg, mag};
                    m_valid_next = 1'b1;
                    state_next   = bpm_pkg::ST_IDLE;
                end
            end
            default: state_next = bpm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bpm_pkg::ST_IDLE;
            pwr_reg     <= bpm_pkg::PWR_INIT;
            prev_reg    <= bpm_pkg::PWR_INIT;
            fv_reg      <= '0;
            primed_reg  <= 1'b0;
            low_reg     <= '0;
            deb_reg     <= '0;
            sflag_reg   <= 1'b0;
            vflag_reg   <= 1'b0;
            last_reg    <= '0;
            pct_reg     <= bpm_pkg::PCT_EMPTY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pwr_reg     <= pwr_next;
            prev_reg    <= prev_next;
            fv_reg      <= fv_next;
            primed_reg  <= primed_next;
            low_reg     <= low_next;
            deb_reg     <= deb_next;
            sflag_reg   <= sflag_next;
            vflag_reg   <= vflag_next;
            last_reg    <= last_next;
            pct_reg     <= pct_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rq_reg        <= rq_next;
        d_reg         <= d_next;
        pin_reg       <= pin_next;
        usb_gt_reg    <= usb_gt_next;
        seg_reg       <= seg_next;
        usb_out_reg   <= usb_out_next;
        sleep_out_reg <= sleep_out_next;
        chg_out_reg   <= chg_out_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == bpm_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_primed_after_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpm_pkg::ST_PFIN) |-> primed_reg)
        else $error("filter not primed after a sample");

    a_low_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (low_reg <= bpm_pkg::LOW_W'(LOW_LIMIT)) &&
        (deb_reg <= bpm_pkg::DEB_W'(DEBOUNCE_LIMIT)))
        else $error("low or debounce counter past its limit");

    a_report_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpm_pkg::ST_REPORT) |=> (!sflag_reg && !vflag_reg))
        else $error("report item left a change flag set");

    a_prev_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpm_pkg::ST_IDLE) |-> (prev_reg == pwr_reg))
        else $error("previous state out of step with power state");

    a_sleep_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpm_pkg::ST_DONE && sleep_out_reg) |-> (pwr_reg == bpm_pkg::PWR_LOW))
        else $error("sleep request outside battery low state");

endmodule

[rtl/core/battery_power_monitor.sv]
// battery_power_monitor: top level, apb registers, sequencer and shared alu
// depends on bpm_pkg, bpm_regs, bpm_alu and bpm_ctrl
//
// s_ channel carries one item per request: s_tuser 0 is a sample (adc reading
// and charge pin), 1 is a report that returns and clears the change flag.
// m_ channel returns exactly one result item per accepted item.
// configuration goes through the apb port, only while the block is idle: a rule
// for the user, which the block itself does not enforce. a sample walks the
// steps of one shared add/subtract/multiply unit, one operation per cycle:
// m_tvalid rises once ST_DONE has registered the result; a direct load of the
// filter with the new reading skips the ST_FADD and ST_FWR steps.
// a report goes through ST_REPORT and ST_DONE. one item is worked on at a
// time; s_tready is high only while idle, so a new item is taken only after
// the last one has left ST_DONE.
// the result sits in an output register, so the next item is accepted while
// a finished result waits; a stalled m_tready holds that result and stops the
// block only when a second result is ready to leave.
// reset (aresetn low, synchronous) clears the filter, power state, counters,
// change flags and registers to their default values and drops m_tvalid.
module battery_power_monitor #(
    parameter int LOW_LIMIT      = bpm_pkg::LOW_LIMIT_DEF,
    parameter int DEBOUNCE_LIMIT = bpm_pkg::DEBOUNCE_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpm_pkg::APB_AW-1:0]    paddr,
    input  logic [bpm_pkg::APB_DW-1:0]    pwdata,
    output logic [bpm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // adc_mv [11:0], charge_pin_low [12], zero [15:13]
    input  logic [bpm_pkg::S_DATA_W-1:0]  s_tdata,
    // func [0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // filtered_mv [12:0], power_code [15:13], percent [22:16], usb_powered [23],
    // sleep_request [24], changed [25], zero [31:26]
    output logic [bpm_pkg::M_DATA_W-1:0]  m_tdata
);

    bpm_pkg::cfg_t                      cfg;
    bpm_pkg::alu_req_t                  alu_req;
    logic signed [bpm_pkg::PROD_W-1:0]  alu_y;

    bpm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpm_alu u_alu (
        .aclk (aclk),
        .req  (alu_req),
        .y    (alu_y)
    );

    bpm_ctrl #(
        .LOW_LIMIT      (LOW_LIMIT),
        .DEBOUNCE_LIMIT (DEBOUNCE_LIMIT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .alu_req  (alu_req),
        .alu_y    (alu_y)
    );

endmodule

[tb/sv/testbench.sv]
// testbench: self-checking bench for battery_power_monitor; samples and reports are streamed
// in under random idling, registers set over apb, results checked field by field
// against an in-bench model of the monitor; depends on bpm_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpm_pkg::*;

    localparam int LOW_LIMIT   = LOW_LIMIT_DEF;
    localparam int DEB_LIMIT   = DEBOUNCE_LIMIT_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 105;
    localparam int N_PHASES    = 6;
    localparam int N_ROWS      = 25;

    typedef struct packed {
        logic             changed;
        logic             sleep_req;
        logic             usb;
        logic [PCT_W-1:0] pct;
        pwr_t             code;
        logic [MV_W-1:0]  mv;
    } status_t;

    typedef struct packed {
        logic             func;
        logic [ADC_W-1:0] adc;
        logic             pin_low;
        logic             known;
        logic [MV_W-1:0]  mv;
        pwr_t             code;
        logic [PCT_W-1:0] pct;
        logic             usb;
        logic             sleep_req;
        logic             changed;
    } probe_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    battery_power_monitor uut (.*);

    // monitor copy
    cfg_t            cfg;
    logic [FV_W-1:0] filt_q8;
    logic            primed;
    pwr_t            pstate;
    pwr_t            pstate_seen;
    int unsigned     low_cnt;
    int unsigned     deb_cnt;
    logic            st_flag;
    logic            v_flag;
    logic [MV_W-1:0] last_mv;

    status_t awaited_status [$];
    probe_t  dir_rows [N_ROWS];
    logic    idling;
    int      errors;
    int      cycle_cnt;
    int      n_items;
    int      n_reports;
    int      n_status;
    int      n_sleep;
    int      n_changed;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [PCT_W-1:0] charge_percent(input logic [FV_W-1:0] v,
                                                        input pwr_t st);
        int unsigned x;
        x = v;
        if (st == PWR_CHRG) return PCT_CHRG;
        if (st == PWR_USB) return PCT_USB;
        if (st == PWR_FULL) return PCT_FULL;
        if (x >= 4000 * 256) return PCT_FULL;
        if (x >= 3800 * 256) return PCT_W'(80 + (x - 3800 * 256) / (10 * 256));
        if (x >= 3650 * 256) return PCT_W'(40 + ((x - 3650 * 256) * 4) / (15 * 256));
        if (x >= 3500 * 256) return PCT_W'(10 + (x - 3500 * 256) / (5 * 256));
        if (x >= 3300 * 256) return PCT_W'((x - 3300 * 256) / (20 * 256));
        return PCT_EMPTY;
    endfunction

    task automatic clear_monitor();
        cfg = '{RST_STEP_THR, RST_SMOOTH, RST_USB_MV, RST_MIN_MV, RST_CHG_THR};
        filt_q8 = '0;
        primed = 1'b0;
        pstate = PWR_INIT;
        pstate_seen = PWR_INIT;
        low_cnt = 0;
        deb_cnt = 0;
        st_flag = 1'b0;
        v_flag = 1'b0;
        last_mv = '0;
    endtask

    task automatic advance_monitor(input logic func, input logic [ADC_W-1:0] adc,
                                   input logic pin_low, output status_t st);
        int unsigned raw, rq, diff, w, mag, dmv;
        logic        usb;
        st = '0;
        if (!func) begin
            raw = adc * 2 + 65;
            if (raw > 8191) raw = 8191;
            rq = raw << FRAC_W;
            diff = rq > filt_q8 ? rq - filt_q8 : filt_q8 - rq;
            if (!primed || diff > (32'(cfg.step_thr) << FRAC_W)) begin
                filt_q8 = FV_W'(rq);
            end else begin
                w = cfg.smooth > 256 ? 256 : cfg.smooth;
                filt_q8 = FV_W'((w * rq + (256 - w) * filt_q8) >> FRAC_W);
            end
            primed = 1'b1;
            usb = (filt_q8 > (32'(cfg.usb_mv) << FRAC_W)) || pin_low;
            if (usb) begin
                low_cnt = 0;
                deb_cnt = 0;
                if (pin_low) begin
                    pstate = PWR_CHRG;
                end else if (filt_q8 > (32'(cfg.usb_mv) << FRAC_W) &&
                             (pstate == PWR_CHRG || pstate == PWR_FULL)) begin
                    pstate = PWR_FULL;
                end else if (pstate == PWR_INIT) begin
                    pstate = PWR_USB;
                end
            end else if (pstate == PWR_FULL || pstate == PWR_INIT) begin
                pstate = PWR_RUN;
                deb_cnt = 0;
                low_cnt = 0;
            end else if (filt_q8 < (32'(cfg.min_mv) << FRAC_W)) begin
                pstate = PWR_LOW;
                if (low_cnt < LOW_LIMIT) begin
                    low_cnt++;
                end else begin
                    deb_cnt = 0;
                    st.sleep_req = 1'b1;
                end
            end else begin
                low_cnt = 0;
                if (deb_cnt < DEB_LIMIT) deb_cnt++;
                else pstate = PWR_RUN;
            end
            mag = filt_q8 >> FRAC_W;
            dmv = mag > last_mv ? mag - last_mv : last_mv - mag;
            if (dmv >= cfg.chg_thr) v_flag = 1'b1;
            if (pstate != pstate_seen) begin
                st_flag = 1'b1;
                pstate_seen = pstate;
            end
            st.usb = usb;
        end else begin
            st.changed = st_flag || v_flag;
            if (st.changed) last_mv = MV_W'(filt_q8 >> FRAC_W);
            st_flag = 1'b0;
            v_flag = 1'b0;
        end
        st.mv = MV_W'(filt_q8 >> FRAC_W);
        st.code = pstate;
        st.pct = charge_percent(filt_q8, pstate);
    endtask

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (errors < 50)
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    task automatic check_status(input logic [M_DATA_W-1:0] data);
        status_t got, want;
        got = data[$bits(status_t)-1:0];
        n_status++;
        if (got.sleep_req === 1'b1) n_sleep++;
        if (got.changed === 1'b1) n_changed++;
        if (awaited_status.size() == 0) begin
            if (errors < 50)
                $display("%0t result item with nothing expected: %h", $time, data);
            errors++;
        end else begin
            want = awaited_status.pop_front();
            if (got.mv !== want.mv) flag_field("filtered_mv", want.mv, got.mv);
            if (got.code !== want.code) flag_field("power_code", want.code, got.code);
            if (got.pct !== want.pct) flag_field("percent", want.pct, got.pct);
            if (got.usb !== want.usb) flag_field("usb_powered", want.usb, got.usb);
            if (got.sleep_req !== want.sleep_req)
                flag_field("sleep_request", want.sleep_req, got.sleep_req);
            if (got.changed !== want.changed) flag_field("changed", want.changed, got.changed);
        end
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                check_status(m_tdata);
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idling && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] rd;
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        rd = prdata;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== val) begin
            $display("%0t readback of register %s: expected %0d, got %0d",
                     $time, idx.name(), val, rd);
            errors++;
        end
    endtask

    task automatic load_settings(input cfg_t c);
        apb_write(REG_STEP_THR, 32'(c.step_thr));
        apb_write(REG_SMOOTH, 32'(c.smooth));
        apb_write(REG_USB_MV, 32'(c.usb_mv));
        apb_write(REG_MIN_MV, 32'(c.min_mv));
        apb_write(REG_CHG_THR, 32'(c.chg_thr));
        cfg = c;
    endtask

    function automatic cfg_t pick_settings(input int ph);
        cfg_t c;
        case (ph)
            0: c = '{RST_STEP_THR, RST_SMOOTH, RST_USB_MV, RST_MIN_MV, RST_CHG_THR};
            1: c = '{13'd0, 9'd0, 13'd8191, 13'd0, 13'd0};
            2: c = '{13'd8191, 9'd256, 13'd0, 13'd8191, 13'd8191};
            3: c = '{13'd8191, 9'd511, 13'd4180, 13'd3600, 13'd50};
            4: c = '{MV_W'($urandom_range(10, 400)), W_W'($urandom_range(1, 255)),
                     MV_W'($urandom_range(3900, 4400)), MV_W'($urandom_range(3200, 3700)),
                     MV_W'($urandom_range(1, 60))};
            default: c = '{13'd200, 9'd64, 13'd4100, 13'd3400, 13'd10};
        endcase
        return c;
    endfunction

    // caller sits on a rising edge; returns on the edge that takes the item
    task automatic feed(input logic func, input logic [ADC_W-1:0] adc, input logic pin_low,
                        input logic known, input status_t typed);
        status_t st;
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {3'b000, pin_low, adc};
        do @(negedge aclk); while (s_tready !== 1'b1);
        @(posedge aclk);
        advance_monitor(func, adc, pin_low, st);
        awaited_status.push_back(known ? typed : st);
        n_items++;
        if (func) n_reports++;
    endtask

    function automatic logic [ADC_W-1:0] adc_for(input int mv);
        if (mv <= 65) return '0;
        if (mv >= 65 + 2 * 4095) return '1;
        return ADC_W'((mv - 65) / 2);
    endfunction

    task automatic sample_at(input int mv, input logic pin_low);
        if ($urandom_range(0, 5) == 0)
            feed(1'b1, ADC_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)), 1'b0, '0);
        feed(1'b0, adc_for(mv), pin_low, 1'b0, '0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_status.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic run_phase(input logic last);
        int start, mv, top;
        start = n_items;
        while (n_items - start < PHASE_ITEMS) begin
            idling = !last && ($urandom_range(0, 3) != 0);
            top = cfg.min_mv > 66 ? cfg.min_mv - 1 : 65;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    mv = $urandom_range(3100, 4350);
                    repeat ($urandom_range(6, 16)) begin
                        mv = mv + int'($urandom_range(0, 80)) - 40;
                        sample_at(mv, 1'b0);
                    end
                end
                4, 5: begin
                    mv = $urandom_range(65, top);
                    repeat ($urandom_range(8, 15))
                        sample_at(mv - int'($urandom_range(0, 10)), 1'b0);
                end
                6, 7: begin
                    repeat ($urandom_range(2, 6)) sample_at($urandom_range(3700, 4300), 1'b1);
                    repeat ($urandom_range(2, 5)) sample_at($urandom_range(4200, 4400), 1'b0);
                    repeat ($urandom_range(1, 4)) sample_at($urandom_range(3850, 4150), 1'b0);
                end
                8: begin
                    repeat ($urandom_range(3, 10))
                        feed(1'($urandom_range(0, 1)), ADC_W'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)), 1'b0, '0);
                end
                default: begin
                    repeat ($urandom_range(3, 6)) sample_at($urandom_range(65, top), 1'b0);
                    mv = cfg.min_mv + $urandom_range(20, 200);
                    repeat ($urandom_range(3, 6)) sample_at(mv, 1'b0);
                end
            endcase
        end
    endtask

    initial begin
        status_t typed;
        errors = 0;
        cycle_cnt = 0;
        n_items = 0;
        n_reports = 0;
        n_status = 0;
        n_sleep = 0;
        n_changed = 0;
        idling = 1'b1;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        clear_monitor();

        // func adc pin known | filtered_mv code percent usb sleep changed
        dir_rows = '{
            '{1'b0, 12'd4095, 1'b0, 1'b1, 13'd8191, PWR_USB,  7'd102, 1'b1, 1'b0, 1'b0},
            '{1'b1, 12'd0,    1'b0, 1'b1, 13'd8191, PWR_USB,  7'd102, 1'b0, 1'b0, 1'b1},
            '{1'b1, 12'd0,    1'b0, 1'b1, 13'd8191, PWR_USB,  7'd102, 1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b1, 13'd65,   PWR_LOW,  7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd0,    1'b0, 1'b1, 13'd65,   PWR_LOW,  7'd0,   1'b0, 1'b1, 1'b0},
            '{1'b1, 12'd0,    1'b0, 1'b1, 13'd65,   PWR_LOW,  7'd0,   1'b0, 1'b0, 1'b1},
            '{1'b0, 12'd1800, 1'b1, 1'b1, 13'd3665, PWR_CHRG, 7'd101, 1'b1, 1'b0, 1'b0},
            '{1'b0, 12'd2100, 1'b0, 1'b1, 13'd4265, PWR_FULL, 7'd100, 1'b1, 1'b0, 1'b0},
            '{1'b0, 12'd1900, 1'b0, 1'b1, 13'd3865, PWR_RUN,  7'd86,  1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd1950, 1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd1650, 1'b0, 1'b1, 13'd3365, PWR_RUN,  7'd3,   1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd1750, 1'b0, 1'b1, 13'd3565, PWR_RUN,  7'd23,  1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd1800, 1'b0, 1'b1, 13'd3575, PWR_RUN,  7'd25,  1'b0, 1'b0, 1'b0},
            '{1'b0, 12'd1600, 1'b0, 1'b1, 13'd3265, PWR_LOW,  7'd0,   1'b0, 1'b0, 1'b0},
            '{1'b1, 12'd4095, 1'b1, 1'b1, 13'd3265, PWR_LOW,  7'd0,   1'b0, 1'b0, 1'b1},
            '{1'b0, 12'd1700, 1'b0, 1'b0, 13'd0,    PWR_INIT, 7'd0,   1'b0, 1'b0, 1'b0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            typed.mv = dir_rows[i].mv;
            typed.code = dir_rows[i].code;
            typed.pct = dir_rows[i].pct;
            typed.usb = dir_rows[i].usb;
            typed.sleep_req = dir_rows[i].sleep_req;
            typed.changed = dir_rows[i].changed;
            feed(dir_rows[i].func, dir_rows[i].adc, dir_rows[i].pin_low,
                 dir_rows[i].known, typed);
        end
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            idling = 1'b0;
            load_settings(pick_settings(ph));
            run_phase(ph == N_PHASES - 1);
            settle();
        end

        $display("run covered %0d items (%0d reports) over %0d register settings",
                 n_items, n_reports, N_PHASES + 1);
        $display("%0d results checked, %0d sleep requests and %0d change reports seen",
                 n_status, n_sleep, n_changed);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bpm_pkg.sv
rtl/core/bpm_alu.sv
rtl/core/bpm_regs.sv
rtl/core/bpm_ctrl.sv
rtl/core/battery_power_monitor.sv
tb/sv/testbench.sv
